/* design/nsff_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nsff_pkg;

   localparam int RING_DEPTH = 256;
   localparam int PTR_W      = $clog2(RING_DEPTH);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_TWO    = 8'h32;

   localparam logic [7:0] HEX_HI_MASK = 8'hF0;
   localparam logic [7:0] HEX_LO_MASK = 8'h0F;

   // field index that carries the fix indication
   localparam logic [3:0] RMC_FIX_FIELD = 4'd1;
   localparam logic [3:0] GGA_FIX_FIELD = 4'd5;
   localparam logic [3:0] FIELD_MAX     = 4'd15;

   localparam logic [2:0] TAG_LAST = 3'd4;

   // input selector
   localparam logic FUNC_RECV = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [7:0] {
      ST_HUNT  = 8'b0000_0001,
      ST_TAG   = 8'b0000_0010,
      ST_COMMA = 8'b0000_0100,
      ST_DATA  = 8'b0000_1000,
      ST_CKHI  = 8'b0001_0000,
      ST_CKLO  = 8'b0010_0000,
      ST_CR    = 8'b0100_0000,
      ST_LF    = 8'b1000_0000
   } step_type;

   typedef struct packed {
      logic read_valid;
      logic byte_dropped;
      logic sentence_done;
      logic sentence_kind;
      logic fix_valid;
      logic sentence_rejected;
   } rsp_type;

   function automatic logic [7:0] tag_rmc_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h47; // G
         3'd1:    ch = 8'h50; // P
         3'd2:    ch = 8'h52; // R
         3'd3:    ch = 8'h4D; // M
         default: ch = 8'h43; // C
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] tag_gga_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h47; // G
         3'd1:    ch = 8'h50; // P
         3'd2:    ch = 8'h47; // G
         3'd3:    ch = 8'h47; // G
         default: ch = 8'h41; // A
      endcase
      return ch;
   endfunction

   // value of an uppercase hex digit, 16 for anything else
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h37);
      end else begin
         v = 5'd16;
      end
      return v;
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* design/nsff_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module nsff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/nmea_sentence_filter_fifo_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Each accepted input beat yields a result beat through the s1 and output
// registers. Throughput: one beat per cycle while rsp_tready does not stall
// the output; the ring RAM takes one write or one read each cycle.
// Reset clears pointers, parser state and the pipeline; the ring RAM is
// not cleared, only committed entries are ever read back.
module nmea_sentence_filter_fifo_top
   import nsff_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [0] read_valid, [8:1] read_data,
                                         // [9] byte_dropped, [10] sentence_done,
                                         // [11] fix_valid, [12] sentence_rejected,
                                         // [15:13] zero
   output logic             rsp_tuser    // [0] sentence_kind
);

   logic [PTR_W-1:0] commit_ptr_ff, commit_ptr_in;
   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   step_type         step_ff, step_in;
   logic [2:0]       tag_pos_ff, tag_pos_in;
   logic [1:0]       tag_flags_ff, tag_flags_in;
   logic [7:0]       parity_ff, parity_in;
   logic [3:0]       field_cnt_ff, field_cnt_in;
   logic [7:0]       first_char_ff, first_char_in;
   logic             fix_ff, fix_in;

   logic             s1_valid_ff, s1_valid_in;
   rsp_type          s1_res_ff, s1_res_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_res_ff, out_res_in;
   logic [7:0]       out_data_ff, out_data_in;

   logic             accept;
   logic             s1_move;
   logic             out_load;
   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_wr_addr;
   logic             ram_rd_en;
   logic [7:0]       ram_rd_data;

   logic [7:0]       c;
   logic             full;
   logic             fail;
   logic [1:0]       flags_chk;
   logic [7:0]       first_upd;
   logic             fix_hit;

   assign c         = req_tdata;
   assign out_load  = !out_valid_ff || rsp_tready;
   assign s1_move   = s1_valid_ff && out_load;
   assign req_tready = !s1_valid_ff || out_load;
   assign accept    = req_tvalid && req_tready;
   assign full      = (ring_next(write_ptr_ff) == read_ptr_ff);

   assign ram_rd_en = accept && (req_tuser == FUNC_READ);

   always_comb begin
      commit_ptr_in = commit_ptr_ff;
      read_ptr_in   = read_ptr_ff;
      write_ptr_in  = write_ptr_ff;
      step_in       = step_ff;
      tag_pos_in    = tag_pos_ff;
      tag_flags_in  = tag_flags_ff;
      parity_in     = parity_ff;
      field_cnt_in  = field_cnt_ff;
      first_char_in = first_char_ff;
      fix_in        = fix_ff;
      s1_res_in     = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = write_ptr_ff;
      fail          = 1'b0;
      flags_chk     = '0;
      first_upd     = first_char_ff;
      fix_hit       = 1'b0;

      if (accept) begin
         if (req_tuser == FUNC_READ) begin
            if (read_ptr_ff != commit_ptr_ff) begin
               s1_res_in.read_valid = 1'b1;
               read_ptr_in = ring_next(read_ptr_ff);
            end
         end else if (full) begin
            s1_res_in.byte_dropped = 1'b1;
         end else if (c == CH_DOLLAR) begin
            // restart: drop any partial sentence
            ram_wr_en     = 1'b1;
            ram_wr_addr   = (step_ff != ST_HUNT) ? commit_ptr_ff : write_ptr_ff;
            write_ptr_in  = ring_next(ram_wr_addr);
            step_in       = ST_TAG;
            tag_pos_in    = '0;
            tag_flags_in  = 2'b11;
            parity_in     = CH_STAR;
            field_cnt_in  = '0;
            first_char_in = '0;
            fix_in        = 1'b0;
         end else if (step_ff != ST_HUNT) begin
            ram_wr_en    = 1'b1;
            write_ptr_in = ring_next(write_ptr_ff);
            if (step_ff == ST_TAG || step_ff == ST_COMMA || step_ff == ST_DATA) begin
               parity_in = parity_ff ^ c;
            end
            unique case (step_ff)
               ST_TAG: begin
                  flags_chk = tag_flags_ff & {c == tag_gga_char(tag_pos_ff),
                                              c == tag_rmc_char(tag_pos_ff)};
                  tag_flags_in = flags_chk;
                  if (flags_chk == 2'b00) begin
                     fail = 1'b1;
                  end else if (tag_pos_ff == TAG_LAST) begin
                     step_in = ST_COMMA;
                  end else begin
                     tag_pos_in = tag_pos_ff + 3'd1;
                  end
               end
               ST_COMMA: begin
                  if (c != CH_COMMA || tag_flags_ff == 2'b00) begin
                     fail = 1'b1;
                  end else begin
                     field_cnt_in  = '0;
                     first_char_in = CH_COMMA;
                     step_in       = ST_DATA;
                  end
               end
               ST_DATA: begin
                  // an empty field sees its closing delimiter as first char
                  first_upd     = (first_char_ff == CH_COMMA) ? c : first_char_ff;
                  first_char_in = first_upd;
                  if (c == CH_COMMA || c == CH_STAR) begin
                     if (tag_flags_ff[0]) begin
                        fix_hit = (field_cnt_ff == RMC_FIX_FIELD) && (first_upd == CH_A);
                     end else if (tag_flags_ff[1]) begin
                        fix_hit = (field_cnt_ff == GGA_FIX_FIELD) &&
                                  (first_upd == CH_ONE || first_upd == CH_TWO);
                     end
                     if (fix_hit) begin
                        fix_in = 1'b1;
                     end
                     if (field_cnt_ff != FIELD_MAX) begin
                        field_cnt_in = field_cnt_ff + 4'd1;
                     end
                     first_char_in = CH_COMMA;
                  end
                  if (c == CH_STAR) begin
                     step_in = ST_CKHI;
                  end
               end
               ST_CKHI: begin
                  if (hex_value(c) != {1'b0, 4'((parity_ff & HEX_HI_MASK) >> 4)}) begin
                     fail = 1'b1;
                  end else begin
                     step_in = ST_CKLO;
                  end
               end
               ST_CKLO: begin
                  if (hex_value(c) != {1'b0, 4'(parity_ff & HEX_LO_MASK)}) begin
                     fail = 1'b1;
                  end else begin
                     step_in = ST_CR;
                  end
               end
               ST_CR: begin
                  if (c != CH_CR) begin
                     fail = 1'b1;
                  end else begin
                     step_in = ST_LF;
                  end
               end
               ST_LF: begin
                  if (c != CH_LF) begin
                     fail = 1'b1;
                  end else begin
                     commit_ptr_in = ring_next(write_ptr_ff);
                     step_in       = ST_HUNT;
                     s1_res_in.sentence_done = 1'b1;
                     s1_res_in.sentence_kind = !tag_flags_ff[0];
                     s1_res_in.fix_valid     = fix_ff;
                  end
               end
               default: begin
                  step_in = ST_HUNT;
               end
            endcase
            if (fail) begin
               // rewind to the last committed sentence
               write_ptr_in = commit_ptr_ff;
               step_in      = ST_HUNT;
               s1_res_in.sentence_rejected = 1'b1;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_tready);
      out_res_in   = s1_move ? s1_res_ff : out_res_ff;
      out_data_in  = out_data_ff;
      if (s1_move) begin
         out_data_in = s1_res_ff.read_valid ? ram_rd_data : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commit_ptr_ff <= '0;
         read_ptr_ff   <= '0;
         write_ptr_ff  <= '0;
         step_ff       <= ST_HUNT;
         tag_pos_ff    <= '0;
         tag_flags_ff  <= '0;
         parity_ff     <= '0;
         field_cnt_ff  <= '0;
         first_char_ff <= '0;
         fix_ff        <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         commit_ptr_ff <= commit_ptr_in;
         read_ptr_ff   <= read_ptr_in;
         write_ptr_ff  <= write_ptr_in;
         step_ff       <= step_in;
         tag_pos_ff    <= tag_pos_in;
         tag_flags_ff  <= tag_flags_in;
         parity_ff     <= parity_in;
         field_cnt_ff  <= field_cnt_in;
         first_char_ff <= first_char_in;
         fix_ff        <= fix_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= s1_res_in;
      end
      out_res_ff  <= out_res_in;
      out_data_ff <= out_data_in;
   end

   nsff_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (c),
      .rd_en   (ram_rd_en),
      .rd_addr (read_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.sentence_kind;
   assign rsp_tdata  = {3'b000,
                        out_res_ff.sentence_rejected,
                        out_res_ff.fix_valid,
                        out_res_ff.sentence_done,
                        out_res_ff.byte_dropped,
                        out_data_ff,
                        out_res_ff.read_valid};

endmodule

`default_nettype wire
